/* hw/rtl/ddwm_pkg.sv */
// ----------------------------------------------------------------------------
// ddwm_pkg: shared types and constants of the drive / weapon mixer
// Field widths, register indexes, the configuration struct and the fixed
// reciprocals used by the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package ddwm_pkg;

  // beat field widths
  localparam int PULSE_W = 12;
  localparam int TICK_W  = 32;
  localparam int DUTY_W  = 9;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_WPN_MODE     = 2'd0;
  localparam logic [1:0] REG_INVERT_LEFT  = 2'd1;
  localparam logic [1:0] REG_INVERT_RIGHT = 2'd2;
  localparam logic [1:0] REG_INVERT_WPN   = 2'd3;

  // weapon modes
  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_FLIP    = 2'd1;
  localparam logic [1:0] MODE_AXE     = 2'd2;

  // shared multiplier operand and product widths
  localparam int MUL_AW = 14;
  localparam int MUL_BW = 13;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // floor(m/9) = (m * 7282) >> 16 for m <= 8192
  localparam logic [MUL_BW-1:0] RECIP_9 = 13'd7282;
  localparam int RECIP_9_SHIFT = 16;
  // floor(p/100) = (p * 5243) >> 19 for p <= 10000
  localparam logic [MUL_BW-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_100_SHIFT = 19;

  // stick shaping
  localparam logic [10:0] STICK_LIMIT = 11'd100;
  localparam logic [6:0]  STICK_DEAD  = 7'd10;

  // weapon shaping limits
  localparam logic signed [10:0] WPN_DEAD      = 11'sd20;
  localparam logic signed [10:0] WPN_LIMIT     = 11'sd200;
  localparam logic signed [10:0] WPN_FLIP_TRIG = 11'sd70;
  localparam logic signed [10:0] WPN_AXE_TRIG  = 11'sd50;
  localparam logic [6:0]         FLIP_THR_MIN  = 7'd20;

  localparam logic signed [DUTY_W-1:0] DUTY_FULL    = 9'sd200;
  localparam logic signed [DUTY_W-1:0] DUTY_RETRACT = -9'sd120;
  localparam logic signed [DUTY_W-1:0] DUTY_SELF    = -9'sd40;

  // axe shot timing in ticks
  localparam logic [TICK_W-1:0] SHOT_REARM_TICKS = 32'd50;
  localparam logic [TICK_W-1:0] SHOT_FIRE_END    = 32'd15;
  localparam logic [TICK_W-1:0] SHOT_WAIT_END    = 32'd20;

  typedef struct packed {
    logic [1:0] wpn_mode;
    logic       invert_left_motor;
    logic       invert_right_motor;
    logic       invert_weapon_motor;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/ddwm_if.sv */
// ----------------------------------------------------------------------------
// ddwm_if: stream channels of the drive / weapon mixer
// Valid/ready channels carrying one stick frame in and one duty set out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddwm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddwm_pkg::PULSE_W-1:0] throttle_pulse;
  logic signed [ddwm_pkg::PULSE_W-1:0] steering_pulse;
  logic signed [ddwm_pkg::PULSE_W-1:0] weapon_pulse;
  logic                                flip_inverted;
  logic [ddwm_pkg::TICK_W-1:0]         now_tick;

  modport source (
    output valid, throttle_pulse, steering_pulse, weapon_pulse, flip_inverted, now_tick,
    input  ready
  );
  modport sink (
    input  valid, throttle_pulse, steering_pulse, weapon_pulse, flip_inverted, now_tick,
    output ready
  );
endinterface

interface ddwm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddwm_pkg::DUTY_W-1:0] left_duty;
  logic signed [ddwm_pkg::DUTY_W-1:0] right_duty;
  logic signed [ddwm_pkg::DUTY_W-1:0] weapon_duty;
  logic                               left_brake;
  logic                               right_brake;

  modport source (
    output valid, left_duty, right_duty, weapon_duty, left_brake, right_brake,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, weapon_duty, left_brake, right_brake,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/differential_drive_weapon_mixer.sv */
// ----------------------------------------------------------------------------
// differential_drive_weapon_mixer: tank drive mixer with expo and weapon
// Turns centred throttle, steering and weapon pulses into signed duties for
// the left, right and weapon motors, with brake flags on zero drive duty.
//
// Usage:
//   in_ch takes one frame per beat (three pulse offsets, flip flag, tick).
//   out_ch gives one duty set per frame, in order. Configuration is written
//   through the APB-style port (weapon mode, three inversions) while idle.
//   Each frame runs through an eight-step sequencer around one shared
//   registered multiplier: three scalings by 2/9 and 4/9, then a square and
//   a divide by 100 for each stick. The result is registered at the finish
//   step, at the same edge that makes in_ch ready again, so a new frame is
//   taken only once the last one is through: seven multiplier passes, the
//   finish step and the idle step that takes the next beat.
//   The output register holds a finished duty set until taken; a new frame
//   is accepted meanwhile and its last step waits while out_ch stalls.
//   Reset idles the sequencer, clears the output valid, arms the axe shot and zeroes its start tick.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_weapon_mixer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ddwm_in_if.sink                            in_ch,
  ddwm_out_if.source                         out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ddwm_pkg::APB_AW-1:0]   paddr,
  input  wire logic [ddwm_pkg::APB_DW-1:0]   pwdata,
  output logic      [ddwm_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_THR_SCALE = 4'd1;
  localparam logic [3:0] ST_STR_SCALE = 4'd2;
  localparam logic [3:0] ST_WPN_SCALE = 4'd3;
  localparam logic [3:0] ST_THR_SQ    = 4'd4;
  localparam logic [3:0] ST_THR_DIV   = 4'd5;
  localparam logic [3:0] ST_STR_SQ    = 4'd6;
  localparam logic [3:0] ST_STR_DIV   = 4'd7;
  localparam logic [3:0] ST_FINISH    = 4'd8;

  localparam int W = ddwm_pkg::DUTY_W;

  ddwm_pkg::cfg_t cfg;

  logic [3:0] state_r, state_nxt;

  // latched frame
  logic signed [ddwm_pkg::PULSE_W-1:0] thr_r, str_r, wpn_r;
  logic                                flip_r;
  logic [ddwm_pkg::TICK_W-1:0]         now_r;

  // intermediate magnitudes
  logic [6:0] t_mag_r, t_mag_nxt;
  logic [6:0] s_mag_r, s_mag_nxt;
  logic [9:0] w_mag_r, w_mag_nxt;
  logic [6:0] t_exp_r, t_exp_nxt;

  // axe shot state
  logic [ddwm_pkg::TICK_W-1:0] shot_start_r, shot_start_nxt;
  logic                        shot_armed_r, shot_armed_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic signed [W-1:0] left_r, right_r, weapon_r;
  logic                lbrk_r, rbrk_r;

  // shared multiplier
  logic                              mul_en;
  logic [ddwm_pkg::MUL_AW-1:0]       mul_a;
  logic [ddwm_pkg::MUL_BW-1:0]       mul_b;
  logic [ddwm_pkg::MUL_PW-1:0]       prod_r;

  logic [11:0] thr_abs, str_abs, wpn_abs;
  logic [10:0] scaled_q;
  logic [6:0]  stick_mag;
  logic [6:0]  div100_q;
  logic        finish_go;

  // final mix
  logic signed [W-1:0]  t_val, s_val;
  logic signed [W-1:0]  mix_l, mix_r;
  logic signed [W-1:0]  left_m, right_m, left_f, right_f, left_o, right_o;
  logic signed [10:0]   w_val;
  logic signed [W-1:0]  w_clamped;
  logic signed [W-1:0]  weapon_m, weapon_o;
  logic [ddwm_pkg::TICK_W-1:0] elapsed;
  logic                 shot_new;

  ddwm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  ddwm_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  // clamp a mixed stick sum to +-100 and double it
  function automatic logic signed [W-1:0] mix_clamp2(input logic signed [W-1:0] x);
    logic signed [W-1:0] c;
    if (x > 9'sd100) c = 9'sd100;
    else if (x < -9'sd100) c = -9'sd100;
    else c = x;
    return c <<< 1;
  endfunction

  // pulse magnitudes
  assign thr_abs = thr_r[11] ? 12'(-thr_r) : 12'(thr_r);
  assign str_abs = str_r[11] ? 12'(-str_r) : 12'(str_r);
  assign wpn_abs = wpn_r[11] ? 12'(-wpn_r) : 12'(wpn_r);

  // scaled stick: clamp to 100, deadzone below 10
  assign scaled_q  = prod_r[ddwm_pkg::RECIP_9_SHIFT +: 11];
  assign stick_mag = (scaled_q > ddwm_pkg::STICK_LIMIT) ? 7'(ddwm_pkg::STICK_LIMIT) :
                     (7'(scaled_q) < ddwm_pkg::STICK_DEAD) ? 7'd0 : 7'(scaled_q);
  assign div100_q  = prod_r[ddwm_pkg::RECIP_100_SHIFT +: 7];

  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  // sequencer and multiplier operand select
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = ddwm_pkg::RECIP_9;
    t_mag_nxt = t_mag_r;
    s_mag_nxt = s_mag_r;
    w_mag_nxt = w_mag_r;
    t_exp_nxt = t_exp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_THR_SCALE;
      end
      ST_THR_SCALE: begin
        mul_en    = 1'b1;
        mul_a     = {1'b0, thr_abs, 1'b0};
        state_nxt = ST_STR_SCALE;
      end
      ST_STR_SCALE: begin
        t_mag_nxt = stick_mag;
        mul_en    = 1'b1;
        mul_a     = {1'b0, str_abs, 1'b0};
        state_nxt = ST_WPN_SCALE;
      end
      ST_WPN_SCALE: begin
        s_mag_nxt = stick_mag;
        mul_en    = 1'b1;
        mul_a     = {wpn_abs, 2'b00};
        state_nxt = ST_THR_SQ;
      end
      ST_THR_SQ: begin
        w_mag_nxt = prod_r[ddwm_pkg::RECIP_9_SHIFT +: 10];
        mul_en    = 1'b1;
        mul_a     = ddwm_pkg::MUL_AW'(t_mag_r);
        mul_b     = ddwm_pkg::MUL_BW'(t_mag_r);
        state_nxt = ST_THR_DIV;
      end
      ST_THR_DIV: begin
        mul_en    = 1'b1;
        mul_a     = prod_r[ddwm_pkg::MUL_AW-1:0];
        mul_b     = ddwm_pkg::RECIP_100;
        state_nxt = ST_STR_SQ;
      end
      ST_STR_SQ: begin
        t_exp_nxt = div100_q;
        mul_en    = 1'b1;
        mul_a     = ddwm_pkg::MUL_AW'(s_mag_r);
        mul_b     = ddwm_pkg::MUL_BW'(s_mag_r);
        state_nxt = ST_STR_DIV;
      end
      ST_STR_DIV: begin
        mul_en    = 1'b1;
        mul_a     = prod_r[ddwm_pkg::MUL_AW-1:0];
        mul_b     = ddwm_pkg::RECIP_100;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // signed shaped sticks, steering halved
  assign t_val = thr_r[11] ? -$signed({2'b00, t_exp_r}) : $signed({2'b00, t_exp_r});
  assign s_val = str_r[11] ? -$signed({3'b000, div100_q[6:1]})
                           : $signed({3'b000, div100_q[6:1]});
  assign mix_l  = t_val + s_val;
  assign mix_r  = t_val - s_val;
  assign left_m  = mix_clamp2(mix_l);
  assign right_m = mix_clamp2(mix_r);

  // flip swaps and negates, then per-motor inversion
  assign left_f  = flip_r ? -right_m : left_m;
  assign right_f = flip_r ? -left_m  : right_m;
  assign left_o  = cfg.invert_left_motor  ? -left_f  : left_f;
  assign right_o = cfg.invert_right_motor ? -right_f : right_f;

  // weapon value and its symmetric clamp
  assign w_val = wpn_r[11] ? -$signed({1'b0, w_mag_r}) : $signed({1'b0, w_mag_r});
  assign w_clamped = (w_val > ddwm_pkg::WPN_LIMIT)  ? ddwm_pkg::DUTY_FULL :
                     (w_val < -ddwm_pkg::WPN_LIMIT) ? -ddwm_pkg::DUTY_FULL :
                     W'(w_val);

  // axe shot timing
  assign elapsed  = now_r - shot_start_r;
  assign shot_new = (elapsed >= ddwm_pkg::SHOT_REARM_TICKS) || shot_armed_r;

  // weapon mode shaping
  always_comb begin
    weapon_m       = '0;
    shot_start_nxt = shot_start_r;
    shot_armed_nxt = shot_armed_r;
    case (cfg.wpn_mode)
      ddwm_pkg::MODE_FLIP: begin
        if (w_val > ddwm_pkg::WPN_FLIP_TRIG) weapon_m = ddwm_pkg::DUTY_FULL;
        else if (w_val < -ddwm_pkg::WPN_FLIP_TRIG) weapon_m = w_clamped;
        else if (t_exp_r > ddwm_pkg::FLIP_THR_MIN) weapon_m = ddwm_pkg::DUTY_SELF;
        else weapon_m = '0;
      end
      ddwm_pkg::MODE_AXE: begin
        if (w_val < -ddwm_pkg::WPN_DEAD) begin
          weapon_m = w_clamped;
        end else if (w_val > ddwm_pkg::WPN_AXE_TRIG) begin
          if (shot_new) begin
            shot_start_nxt = now_r;
            shot_armed_nxt = 1'b0;
            weapon_m       = ddwm_pkg::DUTY_FULL;
          end else if (elapsed < ddwm_pkg::SHOT_FIRE_END) begin
            weapon_m = ddwm_pkg::DUTY_FULL;
          end else if (elapsed < ddwm_pkg::SHOT_WAIT_END) begin
            weapon_m = '0;
          end else begin
            weapon_m = ddwm_pkg::DUTY_RETRACT;
          end
        end else begin
          shot_armed_nxt = 1'b1;
          weapon_m       = '0;
        end
      end
      default: begin
        if (w_val < ddwm_pkg::WPN_DEAD && w_val > -ddwm_pkg::WPN_DEAD) weapon_m = '0;
        else weapon_m = w_clamped;
      end
    endcase
  end

  assign weapon_o = cfg.invert_weapon_motor ? -weapon_m : weapon_m;

  assign out_valid_nxt = finish_go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      shot_start_r <= '0;
      shot_armed_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish_go) begin
        shot_start_r <= shot_start_nxt;
        shot_armed_r <= shot_armed_nxt;
      end
    end
  end

  // frame capture and working registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      thr_r  <= in_ch.throttle_pulse;
      str_r  <= in_ch.steering_pulse;
      wpn_r  <= in_ch.weapon_pulse;
      flip_r <= in_ch.flip_inverted;
      now_r  <= in_ch.now_tick;
    end
    t_mag_r <= t_mag_nxt;
    s_mag_r <= s_mag_nxt;
    w_mag_r <= w_mag_nxt;
    t_exp_r <= t_exp_nxt;
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      left_r   <= left_o;
      right_r  <= right_o;
      weapon_r <= weapon_o;
      lbrk_r   <= (left_o == '0);
      rbrk_r   <= (right_o == '0);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_duty   = left_r;
  assign out_ch.right_duty  = right_r;
  assign out_ch.weapon_duty = weapon_r;
  assign out_ch.left_brake  = lbrk_r;
  assign out_ch.right_brake = rbrk_r;

endmodule

`default_nettype wire

/* hw/rtl/ddwm_mul.sv */
// ----------------------------------------------------------------------------
// ddwm_mul: shared registered multiplier
// Unsigned multiply with the product held in a register, used once per
// multiplier step for scaling, squaring and reciprocal division.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwm_mul (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ddwm_pkg::MUL_AW-1:0]   op_a,
  input  wire logic [ddwm_pkg::MUL_BW-1:0]   op_b,
  output logic      [ddwm_pkg::MUL_PW-1:0]   prod_r
);

  logic [ddwm_pkg::MUL_PW-1:0] prod_nxt;

  // product of the current step
  always_comb begin
    prod_nxt = ddwm_pkg::MUL_PW'(op_a) * ddwm_pkg::MUL_PW'(op_b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ddwm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ddwm_cfg_regs: configuration registers of the drive / weapon mixer
// APB-style write and read of weapon mode and the three motor inversions.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwm_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ddwm_pkg::APB_AW-1:0]   paddr,
  input  wire logic [ddwm_pkg::APB_DW-1:0]   pwdata,
  output logic      [ddwm_pkg::APB_DW-1:0]   prdata,
  output ddwm_pkg::cfg_t                     cfg
);

  ddwm_pkg::cfg_t cfg_r;
  ddwm_pkg::cfg_t cfg_nxt;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        ddwm_pkg::REG_WPN_MODE:     cfg_nxt.wpn_mode            = pwdata[1:0];
        ddwm_pkg::REG_INVERT_LEFT:  cfg_nxt.invert_left_motor   = pwdata[0];
        ddwm_pkg::REG_INVERT_RIGHT: cfg_nxt.invert_right_motor  = pwdata[0];
        ddwm_pkg::REG_INVERT_WPN:   cfg_nxt.invert_weapon_motor = pwdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      ddwm_pkg::REG_WPN_MODE:     prdata = ddwm_pkg::APB_DW'(cfg_r.wpn_mode);
      ddwm_pkg::REG_INVERT_LEFT:  prdata = ddwm_pkg::APB_DW'(cfg_r.invert_left_motor);
      ddwm_pkg::REG_INVERT_RIGHT: prdata = ddwm_pkg::APB_DW'(cfg_r.invert_right_motor);
      ddwm_pkg::REG_INVERT_WPN:   prdata = ddwm_pkg::APB_DW'(cfg_r.invert_weapon_motor);
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sim/differential_drive_weapon_mixer_tb.sv */
// ----------------------------------------------------------------------------
// differential_drive_weapon_mixer_tb: self-checking bench for the tank mixer
// Sends stick frames with random gaps while the duty sink stalls at random.
// A behavioral mixer predicts every duty set, and each beat out is checked
// against it. Registers change only between phases, with read-back. Directed
// frames hit the clamps, dead bands, flip-hard edges and the axe shot timing.
// Random phases follow, under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module differential_drive_weapon_mixer_tb;

  localparam int     CLK_HALF_NS   = 5;
  localparam int     SETTLE_CYCLES = 20;
  localparam int     MAX_WAIT      = 13;
  localparam int     PHASE_FRAMES  = 128;
  localparam int     PHASE_COUNT   = 8;
  localparam longint TIMEOUT_NS    = 5_000_000;

  // unused weapon mode code, behaves as default
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // shaping numbers of the mixer
  localparam int STICK_MAX       = 100;
  localparam int STICK_DEADZONE  = 10;
  localparam int WPN_DEADZONE    = 20;
  localparam int WPN_MAX         = 200;
  localparam int FLIP_TRIG       = 70;
  localparam int AXE_TRIG        = 50;
  localparam int SELF_RIGHT_THR  = 20;
  localparam int SELF_RIGHT_DUTY = -40;
  localparam int RETRACT_DUTY    = -120;

  typedef struct {
    logic signed [ddwm_pkg::PULSE_W-1:0] throttle;
    logic signed [ddwm_pkg::PULSE_W-1:0] steering;
    logic signed [ddwm_pkg::PULSE_W-1:0] weapon;
    logic                                flip;
    logic [ddwm_pkg::TICK_W-1:0]         tick;
  } stick_frame_t;

  typedef struct {
    logic signed [ddwm_pkg::DUTY_W-1:0] left;
    logic signed [ddwm_pkg::DUTY_W-1:0] right;
    logic signed [ddwm_pkg::DUTY_W-1:0] weapon;
    logic                               left_brake;
    logic                               right_brake;
  } duty_set_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ddwm_pkg::APB_AW-1:0] paddr;
  logic [ddwm_pkg::APB_DW-1:0] pwdata;
  logic [ddwm_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  ddwm_in_if  in_ch ();
  ddwm_out_if out_ch ();

  differential_drive_weapon_mixer i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow registers and shot state of the predictor
  ddwm_pkg::cfg_t              cfg_shadow;
  logic [ddwm_pkg::TICK_W-1:0] shot_start;
  logic                        shot_armed;

  duty_set_t                   duty_expect_q[$];
  int                          fail_count;
  int                          frames_sent;
  int                          shots_fired;
  int                          reg_writes;
  bit                          src_idle;
  bit                          sink_idle;
  int unsigned                 sink_hold;
  logic [ddwm_pkg::TICK_W-1:0] stick_clock;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int clip(input int x, input int lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic int dead_zone(input int x, input int band);
    return (x < band && x > -band) ? 0 : x;
  endfunction

  // x*|x|/100, truncated toward zero
  function automatic int expo_curve(input int x);
    int mag;
    mag = (x < 0) ? -x : x;
    return (x * mag) / 100;
  endfunction

  // axe shot: fire, wait, retract; a new shot after the interval or when armed
  function automatic int axe_shot(input logic [ddwm_pkg::TICK_W-1:0] now);
    logic [ddwm_pkg::TICK_W-1:0] elapsed;
    elapsed = now - shot_start;
    if (elapsed >= ddwm_pkg::SHOT_REARM_TICKS || shot_armed) begin
      shot_start = now;
      shot_armed = 1'b0;
      elapsed    = '0;
      shots_fired++;
    end
    if (elapsed < ddwm_pkg::SHOT_FIRE_END) return WPN_MAX;
    if (elapsed < ddwm_pkg::SHOT_WAIT_END) return 0;
    return RETRACT_DUTY;
  endfunction

  function automatic duty_set_t mix_frame(input stick_frame_t f);
    int        thr;
    int        str;
    int        w;
    int        lft;
    int        rgt;
    int        wpn;
    int        swap;
    duty_set_t d;
    thr = f.throttle;
    str = f.steering;
    w   = f.weapon;
    thr = expo_curve(dead_zone(clip(thr * 10 / 45, STICK_MAX), STICK_DEADZONE));
    str = expo_curve(dead_zone(clip(str * 10 / 45, STICK_MAX), STICK_DEADZONE)) / 2;
    lft = clip(thr + str, STICK_MAX) * 2;
    rgt = clip(thr - str, STICK_MAX) * 2;
    w   = w * 20 / 45;
    // weapon shaping by mode
    case (cfg_shadow.wpn_mode)
      ddwm_pkg::MODE_FLIP: begin
        if (w > FLIP_TRIG) wpn = WPN_MAX;
        else if (w < -FLIP_TRIG) wpn = clip(w, WPN_MAX);
        else if (thr > SELF_RIGHT_THR || thr < -SELF_RIGHT_THR) wpn = SELF_RIGHT_DUTY;
        else wpn = 0;
      end
      ddwm_pkg::MODE_AXE: begin
        if (w < -WPN_DEADZONE) wpn = clip(w, WPN_MAX);
        else if (w > AXE_TRIG) wpn = axe_shot(f.tick);
        else begin
          wpn        = 0;
          shot_armed = 1'b1;
        end
      end
      default: wpn = clip(dead_zone(w, WPN_DEADZONE), WPN_MAX);
    endcase
    // upside down: swap sides and negate
    if (f.flip) begin
      swap = lft;
      lft  = -rgt;
      rgt  = -swap;
    end
    if (cfg_shadow.invert_left_motor) lft = -lft;
    if (cfg_shadow.invert_right_motor) rgt = -rgt;
    if (cfg_shadow.invert_weapon_motor) wpn = -wpn;
    d.left        = lft[ddwm_pkg::DUTY_W-1:0];
    d.right       = rgt[ddwm_pkg::DUTY_W-1:0];
    d.weapon      = wpn[ddwm_pkg::DUTY_W-1:0];
    d.left_brake  = (lft == 0);
    d.right_brake = (rgt == 0);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one frame beat, optionally after a random gap
  task automatic send_frame(input int thr, input int str, input int wpn, input bit flip,
                            input logic [ddwm_pkg::TICK_W-1:0] tick);
    stick_frame_t f;
    int unsigned  gap;
    f.throttle = thr[ddwm_pkg::PULSE_W-1:0];
    f.steering = str[ddwm_pkg::PULSE_W-1:0];
    f.weapon   = wpn[ddwm_pkg::PULSE_W-1:0];
    f.flip     = flip;
    f.tick     = tick;
    gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.throttle_pulse <= f.throttle;
    in_ch.steering_pulse <= f.steering;
    in_ch.weapon_pulse   <= f.weapon;
    in_ch.flip_inverted  <= f.flip;
    in_ch.now_tick       <= f.tick;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    duty_expect_q.push_back(mix_frame(f));
    frames_sent++;
  endtask

  // hold off until every duty set is back and the sequencer has settled
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, then read back the masked value
  task automatic set_reg(input logic [1:0] idx, input logic [ddwm_pkg::APB_DW-1:0] val);
    logic [ddwm_pkg::APB_DW-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    want = '0;
    case (idx)
      ddwm_pkg::REG_WPN_MODE: begin
        cfg_shadow.wpn_mode = val[1:0];
        want[1:0] = val[1:0];
      end
      ddwm_pkg::REG_INVERT_LEFT: begin
        cfg_shadow.invert_left_motor = val[0];
        want[0] = val[0];
      end
      ddwm_pkg::REG_INVERT_RIGHT: begin
        cfg_shadow.invert_right_motor = val[0];
        want[0] = val[0];
      end
      ddwm_pkg::REG_INVERT_WPN: begin
        cfg_shadow.invert_weapon_motor = val[0];
        want[0] = val[0];
      end
      default: ;
    endcase
    reg_writes++;
    // read access
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("prdata of register %0d: expected 0x%0h, got 0x%0h", idx, want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // field value, at random with junk in the unused upper bits
  function automatic logic [ddwm_pkg::APB_DW-1:0] with_junk(input int unsigned field,
                                                            input int w);
    logic [ddwm_pkg::APB_DW-1:0] upper;
    upper = $urandom_range(0, 1) ? ($urandom << w) : '0;
    return upper | field;
  endfunction

  function automatic int pick_stick();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 4095)) - 2048;
      1:       return int'($urandom_range(0, 120)) - 60;
      default: return int'($urandom_range(0, 1000)) - 500;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // stick clamps, dead bands, expo truncation and flip, default weapon
  task automatic test_drive_mixing();
    send_frame(0, 0, 0, 1'b0, 32'h0000_0000);
    send_frame(2047, 2047, 2047, 1'b1, 32'hFFFF_FFFF);
    send_frame(-2048, -2048, -2048, 1'b0, 32'h0000_0000);
    send_frame(44, -44, 44, 1'b0, 32'h0000_1234);
    send_frame(45, -45, -45, 1'b1, 32'h0000_1235);
    send_frame(-207, 206, 45, 1'b0, 32'h0000_1236);
    send_frame(450, -450, 100, 1'b0, 32'h0000_1237);
  endtask

  // flip-hard trigger edges and the self-righting push
  task automatic test_flip_hard();
    wait_idle();
    set_reg(ddwm_pkg::REG_WPN_MODE, ddwm_pkg::APB_DW'(ddwm_pkg::MODE_FLIP));
    send_frame(0, 0, 160, 1'b0, 32'd10);
    send_frame(207, 0, 158, 1'b0, 32'd11);
    send_frame(206, 0, -158, 1'b0, 32'd12);
    send_frame(0, 0, -160, 1'b0, 32'd13);
    send_frame(-2048, 0, -2048, 1'b1, 32'd14);
  endtask

  // axe shot phases, re-arm on release, tick wrap, reverse and trigger edges
  task automatic test_axe_shot();
    logic [ddwm_pkg::TICK_W-1:0] base;
    base = 32'hFFFF_FFE0;
    wait_idle();
    set_reg(ddwm_pkg::REG_WPN_MODE, ddwm_pkg::APB_DW'(ddwm_pkg::MODE_AXE));
    send_frame(0, 0, 115, 1'b0, base);
    send_frame(0, 0, 113, 1'b0, base + 1);
    send_frame(0, 0, 300, 1'b0, base + 2);
    send_frame(0, 0, 2047, 1'b0, base + 16);
    send_frame(0, 0, 300, 1'b0, base + 17);
    send_frame(0, 0, 300, 1'b0, base + 21);
    send_frame(0, 0, 300, 1'b0, base + 22);
    send_frame(0, 0, 300, 1'b0, base + 51);
    send_frame(0, 0, 300, 1'b0, base + 52);
    send_frame(0, 0, -48, 1'b0, base + 53);
    send_frame(0, 0, -47, 1'b0, base + 54);
  endtask

  // all inversions with junk in the upper bits, unused mode code
  task automatic test_inversions();
    wait_idle();
    set_reg(ddwm_pkg::REG_WPN_MODE, 32'hFFFF_FFFF);
    set_reg(ddwm_pkg::REG_INVERT_LEFT, 32'hFFFF_FFFF);
    set_reg(ddwm_pkg::REG_INVERT_RIGHT, 32'h0000_0003);
    set_reg(ddwm_pkg::REG_INVERT_WPN, 32'h8000_0001);
    send_frame(450, -450, 2047, 1'b0, 32'd100);
    send_frame(0, 0, -2048, 1'b1, 32'd101);
    send_frame(2047, -2048, 30, 1'b1, 32'd102);
  endtask

  // random phases; weapon pulses come in runs so axe shots play out fully
  task automatic test_random_phases();
    int         phase;
    int         n;
    int         run_left;
    int         run_kind;
    int         wpn;
    logic [1:0] mode_pick;
    logic [2:0] inv;
    run_left    = 0;
    run_kind    = 0;
    stick_clock = $urandom;
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          mode_pick = ddwm_pkg::MODE_DEFAULT;
          inv       = 3'b000;
        end
        1: begin
          mode_pick = MODE_SPARE;
          inv       = 3'b111;
        end
        2: begin
          mode_pick = ddwm_pkg::MODE_AXE;
          inv       = 3'($urandom);
        end
        3: begin
          mode_pick = ddwm_pkg::MODE_FLIP;
          inv       = 3'($urandom);
        end
        default: begin
          mode_pick = $urandom_range(0, 1) ? ddwm_pkg::MODE_AXE : 2'($urandom);
          inv       = 3'($urandom);
        end
      endcase
      set_reg(ddwm_pkg::REG_WPN_MODE, with_junk(32'(mode_pick), 2));
      set_reg(ddwm_pkg::REG_INVERT_LEFT, with_junk(32'(inv[0]), 1));
      set_reg(ddwm_pkg::REG_INVERT_RIGHT, with_junk(32'(inv[1]), 1));
      set_reg(ddwm_pkg::REG_INVERT_WPN, with_junk(32'(inv[2]), 1));
      for (n = 0; n < PHASE_FRAMES; n++) begin
        // stretches with and without idling on each side
        if (n % 32 == 0) begin
          src_idle  = ($urandom_range(0, 3) != 0);
          sink_idle = ($urandom_range(0, 3) != 0);
        end
        if (n % 150 == 75) wait_idle();
        if (run_left == 0) begin
          run_left = $urandom_range(1, 24);
          run_kind = $urandom_range(0, 9);
        end
        run_left--;
        if (run_kind < 6) wpn = $urandom_range(115, 2047);
        else if (run_kind < 8) wpn = int'($urandom_range(0, 160)) - 47;
        else if (run_kind == 8) wpn = -int'($urandom_range(48, 2048));
        else wpn = int'($urandom_range(0, 4095)) - 2048;
        // tick mostly creeps forward, sometimes jumps anywhere
        if ($urandom_range(0, 39) == 0) stick_clock = $urandom;
        else stick_clock = stick_clock + $urandom_range(0, 7);
        send_frame(pick_stick(), pick_stick(), wpn, 1'($urandom), stick_clock);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // duty sink: random stalls and the check of each beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : duty_sink
    duty_set_t   want;
    int unsigned stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (duty_expect_q.size() == 0) begin
        $error("duty set beat with no frame pending");
        fail_count++;
      end else begin
        want = duty_expect_q.pop_front();
        if (out_ch.left_duty !== want.left) begin
          $error("left_duty: expected %0d, got %0d", want.left, out_ch.left_duty);
          fail_count++;
        end
        if (out_ch.right_duty !== want.right) begin
          $error("right_duty: expected %0d, got %0d", want.right, out_ch.right_duty);
          fail_count++;
        end
        if (out_ch.weapon_duty !== want.weapon) begin
          $error("weapon_duty: expected %0d, got %0d", want.weapon, out_ch.weapon_duty);
          fail_count++;
        end
        if (out_ch.left_brake !== want.left_brake) begin
          $error("left_brake: expected %0d, got %0d", want.left_brake, out_ch.left_brake);
          fail_count++;
        end
        if (out_ch.right_brake !== want.right_brake) begin
          $error("right_brake: expected %0d, got %0d", want.right_brake, out_ch.right_brake);
          fail_count++;
        end
      end
      stall = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
      out_ch.ready <= (stall == 0);
      sink_hold    <= stall;
    end else if (out_ch.ready !== 1'b1) begin
      if (sink_hold <= 1) begin
        out_ch.ready <= 1'b1;
        sink_hold    <= 0;
      end else begin
        sink_hold <= sink_hold - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.throttle_pulse <= '0;
    in_ch.steering_pulse <= '0;
    in_ch.weapon_pulse   <= '0;
    in_ch.flip_inverted  <= 1'b0;
    in_ch.now_tick       <= '0;
    cfg_shadow  = '0;
    shot_start  = '0;
    shot_armed  = 1'b1;
    fail_count  = 0;
    frames_sent = 0;
    shots_fired = 0;
    reg_writes  = 0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_drive_mixing();
    test_flip_hard();
    test_axe_shot();
    test_inversions();
    test_random_phases();

    wait_idle();
    if (duty_expect_q.size() != 0) begin
      $error("%0d duty sets never arrived", duty_expect_q.size());
      fail_count++;
    end
    $display("covered %0d frames and %0d register writes over all weapon modes and inversions",
             frames_sent, reg_writes);
    $display("axe shots started: %0d, failures: %0d", shots_fired, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ddwm_pkg.sv
hw/rtl/ddwm_if.sv
hw/rtl/ddwm_mul.sv
hw/rtl/ddwm_cfg_regs.sv
hw/rtl/differential_drive_weapon_mixer.sv
sim/differential_drive_weapon_mixer_tb.sv
